@@ rtl/core/hpwn_pkg.sv @@
// ----------------------------------------------------------------------------
// Hann power window normaliser package
// Shared widths, register indexes and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package hpwn_pkg;

  localparam int MAX_FRAME   = 4096;
  localparam int COS_DEPTH   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = 13;
  localparam int POS_W       = 12;
  localparam int IDX_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int OUT_W       = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_POWER = 2'd1;

  localparam logic [LEN_W-1:0] LEN_RESET   = 13'd1024;
  localparam logic [3:0]       POWER_RESET = 4'd1;

  // Taylor series denominators (2n-1)*2n for n = 1..7
  localparam longint unsigned TAYLOR_DIV [1:7] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182
  };

  typedef logic [30:0] cos_tab_t [0:COS_DEPTH];

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t          tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint            s;
    for (int j = 0; j <= COS_DEPTH; j++) begin
      x  = longint'(j) * 64'd1686629713 / COS_DEPTH;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      s  = longint'(t);
      for (int n = 1; n <= 7; n++) begin
        t = ((t * x2) >> 30) / TAYLOR_DIV[n];
        if (n[0]) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      tab[j] = s[30:0];
    end
    return tab;
  endfunction

endpackage

@@ rtl/core/hann_power_window_normalizer_top.sv @@
// ----------------------------------------------------------------------------
// Hann power window normaliser
// One sample in flight: a new beat is taken only once the last result is registered.
// The first beat after reset or a frame length or window power write sweeps the
// frame: a divide, each position's window, up to 30 normalise steps, two 32-step
// square roots and a second divide; the shared multiplier sets the pace.
// Synchronous reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module hann_power_window_normalizer_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [hpwn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpwn_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hpwn_pkg::SAMPLE_BITS-1:0] sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hpwn_pkg::OUT_W-1:0]  windowed,
  output logic                               frame_end
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_DIV_PS = 18'h00002,
    S_PH     = 18'h00004,
    S_COS    = 18'h00008,
    S_POW    = 18'h00010,
    S_POWR   = 18'h00020,
    S_SQ     = 18'h00040,
    S_ACC    = 18'h00080,
    S_NORM   = 18'h00100,
    S_SQ_E   = 18'h00200,
    S_SQ_L   = 18'h00400,
    S_DIV_Q  = 18'h00800,
    S_SHIFT  = 18'h01000,
    S_RD     = 18'h02000,
    S_G      = 18'h04000,
    S_G2     = 18'h08000,
    S_Y      = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  localparam hpwn_pkg::cos_tab_t COS_TAB = hpwn_pkg::build_cos_tab();

  state_t state;
  logic [hpwn_pkg::LEN_W-1:0] frame_length;
  logic [3:0]                 window_power;
  logic                       scale_valid;
  logic [31:0]                energy_scale;
  logic [31:0]                phase_step;
  logic [hpwn_pkg::POS_W-1:0] pos;
  logic [hpwn_pkg::POS_W-1:0] widx;
  logic [31:0]                phase;
  logic [63:0]                energy;
  logic [4:0]                 norm_m;
  logic [3:0]                 kc;
  logic [31:0]                w;
  logic [17:0]                h;
  logic [30:0]                cos_q;
  logic                       cos_neg;
  logic [31:0]                wq;
  logic [33:0]                g;
  logic [67:0]                prod;
  logic [33:0]                mul_a;
  logic [33:0]                mul_b;
  logic signed [hpwn_pkg::SAMPLE_BITS-1:0] smp;
  logic [hpwn_pkg::SAMPLE_BITS:0]          mag;
  logic [56:0]                div_num;
  logic [31:0]                div_rem;
  logic [31:0]                div_den;
  logic [5:0]                 div_cnt;
  logic [32:0]                rem_sh;
  logic                       div_ge;
  logic [56:0]                div_num_next;
  logic [31:0]                div_rem_next;
  logic [63:0]                sq_v;
  logic [63:0]                sq_res;
  logic [63:0]                sq_bit;
  logic [63:0]                sq_v_next;
  logic [63:0]                sq_res_next;
  logic [31:0]                sq_re;
  logic [hpwn_pkg::LEN_W-1:0] len;
  logic                       last_pos;
  logic [1:0]                 quad;
  logic [hpwn_pkg::IDX_W-1:0] qidx;
  logic [hpwn_pkg::IDX_W:0]   rom_addr;
  logic [31:0]                w1;
  logic [35:0]                rnd;
  logic [hpwn_pkg::OUT_W-1:0] y;
  logic [31:0]                scale_next;
  logic [4:0]                 sh;
  logic [hpwn_pkg::POS_W-1:0] rd_addr;
  logic                       out_free;

  logic [31:0] wmem [0:hpwn_pkg::MAX_FRAME-1];

  always_comb begin
    if (frame_length < 13'd2) len = 13'd2;
    else if (frame_length > 13'(hpwn_pkg::MAX_FRAME)) len = 13'(hpwn_pkg::MAX_FRAME);
    else len = frame_length;
  end

  assign last_pos = ({1'b0, pos} == len - 13'd1);
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign mag      = smp[hpwn_pkg::SAMPLE_BITS-1] ? 17'(-{smp[15], smp}) : 17'({1'b0, smp});

  assign quad     = phase[31:30];
  assign qidx     = phase[29:20];
  assign rom_addr = quad[0] ? 11'(hpwn_pkg::COS_DEPTH) - {1'b0, qidx} : {1'b0, qidx};
  assign w1       = cos_neg ? 32'h4000_0000 + {1'b0, cos_q} : 32'h4000_0000 - {1'b0, cos_q};

  assign rem_sh       = {div_rem, div_num[56]};
  assign div_ge       = rem_sh >= {1'b0, div_den};
  assign div_num_next = {div_num[55:0], div_ge};
  assign div_rem_next = div_ge ? 32'(rem_sh - {1'b0, div_den}) : rem_sh[31:0];

  always_comb begin
    if (sq_v >= sq_res + sq_bit) begin
      sq_v_next   = sq_v - (sq_res + sq_bit);
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
  end

  always_comb begin
    sh = 5'd0;
    if (norm_m >= 5'd12) begin
      sh = norm_m - 5'd12;
      if (div_num > (57'h0_FFFF_FFFF >> sh)) scale_next = 32'hFFFF_FFFF;
      else scale_next = 32'(div_num << sh);
    end else begin
      sh = 5'd12 - norm_m;
      scale_next = 32'(div_num >> sh);
    end
  end

  assign rnd = 36'((prod[49:0] + 50'h8000) >> 16);
  always_comb begin
    if (rnd >= 36'h80_0000) y = smp[15] ? 24'h80_0000 : 24'h7F_FFFF;
    else y = smp[15] ? 24'(-rnd[23:0]) : rnd[23:0];
  end

  always_comb begin
    unique case (state)
      S_POW:   begin mul_a = {2'b0, w};  mul_b = {16'b0, h}; end
      S_SQ:    begin mul_a = {2'b0, w};  mul_b = {2'b0, w}; end
      S_G:     begin mul_a = {2'b0, wq}; mul_b = {2'b0, energy_scale}; end
      S_Y:     begin mul_a = {17'b0, mag}; mul_b = g; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rd_addr = pos;

  always_ff @(posedge clk) begin
    if (state != S_OUT) prod <= mul_a * mul_b;
    cos_q   <= COS_TAB[rom_addr];
    wq      <= wmem[rd_addr];
    if (state == S_SQ) wmem[widx] <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_length <= hpwn_pkg::LEN_RESET;
      window_power <= hpwn_pkg::POWER_RESET;
      scale_valid  <= 1'b0;
      energy_scale <= '0;
      phase_step   <= '0;
      pos          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == hpwn_pkg::REG_FRAME_LENGTH) begin
          frame_length <= cfg_data;
          scale_valid  <= 1'b0;
          pos          <= '0;
        end else if (cfg_index == hpwn_pkg::REG_WINDOW_POWER) begin
          window_power <= cfg_data[3:0];
          scale_valid  <= 1'b0;
          pos          <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp <= sample;
            if (scale_valid) begin
              state <= S_RD;
            end else begin
              div_num <= 57'h1_0000_0000;
              div_rem <= '0;
              div_den <= 32'(len);
              div_cnt <= '0;
              state   <= S_DIV_PS;
            end
          end
        end
        S_DIV_PS, S_DIV_Q: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd56) begin
            if (state == S_DIV_PS) begin
              phase_step <= div_num_next[31:0];
              widx       <= '0;
              phase      <= '0;
              energy     <= '0;
              state      <= S_PH;
            end else begin
              state <= S_SHIFT;
            end
          end
        end
        S_PH: begin
          cos_neg <= (quad == 2'd1) || (quad == 2'd2);
          state   <= S_COS;
        end
        S_COS: begin
          h  <= 18'((w1 + 32'h2000) >> 14);
          w  <= 32'h0001_0000;
          kc <= window_power;
          state <= (window_power == 4'd0) ? S_SQ : S_POW;
        end
        S_POW: state <= S_POWR;
        S_POWR: begin
          w  <= 32'((prod + 68'h8000) >> 16);
          kc <= kc - 4'd1;
          state <= (kc == 4'd1) ? S_SQ : S_POW;
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          energy <= energy + (prod[63:0] >> 16);
          if ({1'b0, widx} == len - 13'd1) begin
            norm_m <= '0;
            state  <= S_NORM;
          end else begin
            widx  <= widx + 1'b1;
            phase <= phase + phase_step;
            state <= S_PH;
          end
        end
        S_NORM: begin
          if (energy == 64'd0) begin
            energy_scale <= '0;
            scale_valid  <= 1'b1;
            state        <= S_RD;
          end else if (energy < 64'h1000_0000_0000_0000) begin
            energy <= energy << 2;
            norm_m <= norm_m + 5'd1;
          end else begin
            sq_v   <= energy;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= S_SQ_E;
          end
        end
        S_SQ_E, S_SQ_L: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            if (state == S_SQ_E) begin
              sq_re  <= sq_res_next[31:0];
              sq_v   <= {11'b0, len, 40'b0};
              sq_res <= '0;
              sq_bit <= 64'h4000_0000_0000_0000;
              state  <= S_SQ_L;
            end else begin
              div_num <= {sq_res_next[26:0], 30'b0};
              div_rem <= '0;
              div_den <= sq_re;
              div_cnt <= '0;
              state   <= S_DIV_Q;
            end
          end
        end
        S_SHIFT: begin
          energy_scale <= scale_next;
          scale_valid  <= 1'b1;
          state        <= S_RD;
        end
        S_RD: state <= S_G;
        S_G:  state <= S_G2;
        S_G2: begin
          g     <= 34'((prod + 68'h2000_0000) >> 30);
          state <= S_Y;
        end
        S_Y: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            windowed  <= y;
            frame_end <= last_pos;
            out_valid <= 1'b1;
            pos       <= last_pos ? '0 : pos + 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/hpwn_checker.sv @@
// ----------------------------------------------------------------------------
// Hann power window normaliser port checker
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module hpwn_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hpwn_pkg::OUT_W-1:0] windowed,
  input logic                              frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(windowed) && $stable(frame_end))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in work");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result beat appeared too early");

endmodule

bind hann_power_window_normalizer_top hpwn_checker u_hpwn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .windowed  (windowed),
  .frame_end (frame_end)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hann power window normaliser testbench
// Drives frames of samples across several frame lengths and window powers,
// including out-of-range lengths and ignored register indexes. A scoreboard
// recomputes the window, gain and windowed sample for each accepted beat.
// ----------------------------------------------------------------------------
module testbench;
  import hpwn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int STALL_LIMIT = 600000;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef struct {
    logic signed [OUT_W-1:0] windowed;
    logic                    frame_end;
  } beat_t;

  class window_scoreboard;
    longint unsigned cos_q30 [0:COS_DEPTH];
    int unsigned     frame_len_reg;
    int unsigned     power_reg;
    int unsigned     position;
    longint unsigned gain_q30;
    bit              gain_known;
    longint unsigned phase_step;
    beat_t           expected_beats[$];
    int              mismatches;

    function void build_cos();
      longint unsigned x, x2, t;
      longint s;
      for (int j = 0; j <= COS_DEPTH; j++) begin
        x = longint'(j) * 64'd1686629713 / COS_DEPTH;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        s = longint'(t);
        for (int n = 1; n <= 7; n++) begin
          t = ((t * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) s = s - longint'(t);
          else s = s + longint'(t);
        end
        if (s < 0) s = 0;
        if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
        cos_q30[j] = longint'(s);
      end
    endfunction

    function void reset_state();
      frame_len_reg = LEN_RESET;
      power_reg = POWER_RESET;
      position = 0;
      gain_q30 = 0;
      gain_known = 0;
      phase_step = 0;
      build_cos();
    endfunction

    function int unsigned eff_len();
      if (frame_len_reg < 2) return 2;
      if (frame_len_reg > MAX_FRAME) return MAX_FRAME;
      return frame_len_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_LENGTH) frame_len_reg = data;
      else if (idx == REG_WINDOW_POWER) power_reg = data[3:0];
      else return;
      gain_known = 0;
      position = 0;
    endfunction

    function longint unsigned window_at(int unsigned pos);
      logic [31:0] ph;
      int unsigned ix;
      longint c, w1;
      longint unsigned h, w;
      ph = 32'(longint'(pos) * phase_step);
      ix = ph[29:20];
      case (ph[31:30])
        2'd0: c = cos_q30[ix];
        2'd1: c = -longint'(cos_q30[COS_DEPTH - ix]);
        2'd2: c = -longint'(cos_q30[ix]);
        default: c = cos_q30[COS_DEPTH - ix];
      endcase
      w1 = longint'(ONE_Q30) - c;
      h = (longint'(w1) + 8192) >> 14;
      w = 65536;
      for (int k = 0; k < power_reg; k++) w = (w * h + 32768) >> 16;
      return w;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void update_gain();
      int unsigned len;
      longint unsigned e, w, sl, rt, q;
      int m, sh;
      len = eff_len();
      phase_step = (64'd1 << 32) / len;
      e = 0;
      m = 0;
      for (int unsigned i = 0; i < len; i++) begin
        w = window_at(i);
        e += (w * w) >> 16;
      end
      gain_known = 1;
      if (e == 0) begin
        gain_q30 = 0;
        return;
      end
      while (e < (64'd1 << 60)) begin
        e = e << 2;
        m++;
      end
      while (e >= (64'd1 << 62)) begin
        e = e >> 2;
        m--;
      end
      rt = int_sqrt(e);
      sl = int_sqrt(longint'(len) << 40);
      q = (sl << 30) / rt;
      if (m >= 12) begin
        sh = m - 12;
        if (sh >= 32 || q > (64'hFFFF_FFFF >> sh)) gain_q30 = 64'hFFFF_FFFF;
        else gain_q30 = (q << sh) & 64'hFFFF_FFFF;
      end else begin
        sh = 12 - m;
        gain_q30 = (sh >= 64) ? 0 : ((q >> sh) & 64'hFFFF_FFFF);
      end
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
      int unsigned len;
      longint unsigned mag, w, g, p, r;
      longint y;
      bit neg, sat;
      beat_t b;
      if (!gain_known) update_gain();
      len = eff_len();
      if (position >= len) position = 0;
      neg = s < 0;
      mag = neg ? longint'(-longint'(s)) : longint'(s);
      w = window_at(position);
      g = (w * gain_q30 + (64'd1 << 29)) >> 30;
      sat = 0;
      y = 0;
      if (mag != 0 && g > 64'hFFFF_FFFF_FFFF_FFFF / mag) begin
        sat = 1;
      end else begin
        p = mag * g;
        if (p > 64'hFFFF_FFFF_FFFF_FFFF - 32768) begin
          sat = 1;
        end else begin
          r = (p + 32768) >> SAMPLE_BITS;
          if (r > 64'd8388608) sat = 1;
          else y = neg ? -longint'(r) : longint'(r);
        end
      end
      if (sat) y = neg ? -8388608 : 8388607;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      b.windowed = y[OUT_W-1:0];
      b.frame_end = (position == len - 1);
      position = b.frame_end ? 0 : position + 1;
      expected_beats.push_back(b);
    endfunction

    function void check_beat(logic signed [OUT_W-1:0] wv, logic fe);
      beat_t b;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: windowed=%0d frame_end=%0b", wv, fe);
        return;
      end
      b = expected_beats.pop_front();
      if (wv !== b.windowed || fe !== b.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: windowed exp %0d got %0d, frame_end exp %0b got %0b",
                   b.windowed, wv, b.frame_end, fe);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [OUT_W-1:0] windowed;
  logic frame_end;

  window_scoreboard sb = new;
  bit steady = 0;
  int stall_cycles = 0;

  hann_power_window_normalizer_top DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 34);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_sample(sample);
      if (out_valid && out_ready) sb.check_beat(windowed, frame_end);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(logic signed [SAMPLE_BITS-1:0] s);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    sample = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(3) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send(rand_sample());
  endtask

  initial begin
    int len, pw;
    sb.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(16'sh0000); send(16'sh7FFF); send(16'sh8000); send(-16'sd1);
    send(16'sd1); send(16'sh5555); send(16'shAAAA); send(16'sh7FFF);
    send_random(40);

    write_reg(REG_FRAME_LENGTH, 13'd0);
    write_reg(REG_WINDOW_POWER, 13'h1FF0);
    send(16'sh7FFF); send(16'sh8000); send(16'sh7FFF); send(16'sh8000);
    write_reg(REG_FRAME_LENGTH, 13'd1);
    write_reg(REG_WINDOW_POWER, 13'h000F);
    send(16'sh7FFF); send(16'sh8000); send(16'sh7FFF); send(16'sh8000); send(16'sh1234);
    write_reg(REG_FRAME_LENGTH, 13'd2);
    send_random(5);
    write_reg(REG_FRAME_LENGTH, 13'd4096);
    send_random(20);
    write_reg(REG_FRAME_LENGTH, 13'h1FFF);
    write_reg(REG_WINDOW_POWER, 13'd0);
    send_random(12);
    write_reg(REG_SPARE_2, 13'h1ABC);
    send_random(6);
    write_reg(REG_SPARE_3, 13'h0001);
    write_reg(REG_FRAME_LENGTH, 13'd5);
    send_random(7);

    for (int ph = 0; ph < 8; ph++) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(4096, 65) : $urandom_range(64, 2);
      pw = $urandom_range(15);
      write_reg(REG_FRAME_LENGTH, CFG_DATA_W'(len));
      write_reg(REG_WINDOW_POWER, {9'($urandom_range(511)), 4'(pw)});
      steady = (ph == 3);
      send_random(25);
      if (ph == 5) drain();
      send_random(15);
    end
    steady = 0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/hpwn_pkg.sv
rtl/core/hann_power_window_normalizer_top.sv
rtl/core/hpwn_checker.sv
dv/testbench.sv
